// ----- hw/rtl/bwt_pkg.sv -----
// Shared types and constants of the breakpoint and watchpoint table.
package bwt_pkg;

	typedef enum logic [2:0] {
		OP_ADD      = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_TOGGLE   = 3'd2,
		OP_CLR_KIND = 3'd3,
		OP_CLR_ALL  = 3'd4,
		OP_ACCESS   = 3'd5,
		OP_RANGE    = 3'd6,
		OP_EXEC_CHK = 3'd7
	} bwt_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} bwt_state_t;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_EXEC  = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	localparam logic [1:0] HIT_NONE = 2'd0;
	localparam logic [1:0] HIT_SET  = 2'd1;
	localparam logic [1:0] HIT_TEMP = 2'd2;

	localparam logic [31:0] MASK_BYTE  = 32'hFFFF_FFFF;
	localparam logic [31:0] MASK_HALF  = ~32'h1;
	localparam logic [31:0] MASK_WORD  = ~32'h3;
	localparam logic [31:0] MASK_DWORD = ~32'h7;

	typedef struct packed {
		logic [2:0]  operation;
		logic [1:0]  bp_kind;
		logic [31:0] target_address;
		logic [1:0]  access_size_log2;
		logic [31:0] range_bytes;
		logic        is_temporary;
		logic        drop_temporary;
	} bwt_req_t;

	typedef struct packed {
		logic [1:0] hit_state;
		logic       changed;
		logic       table_full;
		logic       read_present;
		logic       write_present;
		logic       exec_present;
	} bwt_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [1:0]  kind;
		logic        temp;
	} bwt_entry_t;

	typedef struct packed {
		bwt_op_t     op;
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [31:0] end_addr;
		logic [1:0]  size;
		logic        temp;
		logic        drop;
	} bwt_cmd_t;

	typedef struct packed {
		logic exact;
		logic exact_temp;
		logic chk;
	} bwt_match_t;

	function automatic logic [31:0] size_mask(input logic [1:0] size);
		logic [31:0] m;
		case (size)
			2'd0: m = MASK_BYTE;
			2'd1: m = MASK_HALF;
			2'd2: m = MASK_WORD;
			default: m = MASK_DWORD;
		endcase
		return m;
	endfunction

endpackage

// ----- hw/rtl/bwt_ifs.sv -----
// Request and response channel interfaces of the breakpoint table.
interface bwt_req_if;
	import bwt_pkg::*;
	logic     valid;
	logic     ready;
	bwt_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bwt_rsp_if;
	import bwt_pkg::*;
	logic     valid;
	logic     ready;
	bwt_rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/bwt_cell.sv -----
// One table entry: compares against the broadcast command and shifts toward the tail.
module bwt_cell import bwt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bwt_entry_t up,
	input  logic       take_en,
	input  logic       give_en,
	input  logic       down_valid,
	input  logic       exec_en,
	input  bwt_cmd_t   cmd,
	output bwt_entry_t ent,
	output bwt_match_t m
);

	logic        valid_q;
	logic [31:0] addr_q;
	logic [1:0]  kind_q;
	logic        temp_q;

	logic        valid_d;
	logic [31:0] addr_d;
	logic [1:0]  kind_d;
	logic        temp_d;
	logic        take;
	logic        give;

	assign take = take_en && up.valid && !valid_q;
	assign give = give_en && valid_q && !down_valid;

	assign ent = '{valid: valid_q, addr: addr_q, kind: kind_q, temp: temp_q};

	always_comb begin
		m.exact = valid_q && (kind_q == cmd.kind) && (addr_q == cmd.addr);
		m.exact_temp = m.exact && temp_q;
		case (cmd.op)
			OP_ACCESS: m.chk = valid_q && (kind_q == cmd.kind) &&
				((addr_q & size_mask(cmd.size)) == cmd.addr);
			OP_RANGE: m.chk = valid_q && (kind_q == KIND_WRITE) &&
				(addr_q >= cmd.addr) && (addr_q < cmd.end_addr);
			default: m.chk = 1'b0;
		endcase
	end

	always_comb begin
		valid_d = valid_q;
		addr_d = addr_q;
		kind_d = kind_q;
		temp_d = temp_q;
		if (take) begin
			valid_d = 1'b1;
			addr_d = up.addr;
			kind_d = up.kind;
			temp_d = up.temp;
		end else if (give) begin
			valid_d = 1'b0;
		end else if (exec_en) begin
			case (cmd.op)
				OP_ADD: begin
					if (m.exact && !cmd.temp)
						temp_d = 1'b0;
				end
				OP_REMOVE, OP_TOGGLE: begin
					if (m.exact)
						valid_d = 1'b0;
				end
				OP_CLR_KIND: begin
					if (kind_q == cmd.kind)
						valid_d = 1'b0;
				end
				OP_CLR_ALL: valid_d = 1'b0;
				OP_EXEC_CHK: begin
					if (m.exact_temp && cmd.drop)
						valid_d = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= valid_d;
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		kind_q <= kind_d;
		temp_q <= temp_d;
	end

endmodule

// ----- hw/rtl/breakpoint_watchpoint_table.sv -----
// Breakpoint and watchpoint table: a chain of entry cells under one command sequencer.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    bwt_req_t: operation, kind, address, size, range, flags
//   rsp      out  valid/ready    bwt_rsp_t: hit_state, changed, table_full, present bits
//
// Each beat passes the execute state, where all cells compare and update in parallel, and
// then the response state, where the present flags are gathered into the output register.
// Entries drift one cell per cycle toward the tail unless a command executes; an add waits
// for a hole in cell 0 unless the table is full. Reset clears every valid bit at once.
// A stalled response holds the sequencer in the response state; no new beat is taken then.
module breakpoint_watchpoint_table import bwt_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input logic   clk,
	input logic   arst_n,
	bwt_req_if.sink   req,
	bwt_rsp_if.source rsp
);

	bwt_state_t state_q;
	bwt_state_t state_d;

	bwt_cmd_t   cmd_q;
	bwt_entry_t ins_entry;
	bwt_entry_t ent [TABLE_ENTRIES];
	bwt_match_t mt  [TABLE_ENTRIES];

	logic       exists;
	logic       any_temp;
	logic       any_chk;
	logic       all_valid;
	logic       rd_pres;
	logic       wr_pres;
	logic       ex_pres;

	logic       shift_en;
	logic       exec_en;
	logic       insert_go;
	logic       res_set;
	logic       load_out;
	logic       accept;
	logic       need_insert;
	logic       add_op;

	logic [1:0] hit_q;
	logic       changed_q;
	logic       full_q;
	logic [1:0] hit_d;
	logic       changed_d;
	logic       full_d;

	logic       out_valid_q;
	bwt_rsp_t   out_data_q;

	assign ins_entry = '{valid: 1'b1, addr: cmd_q.addr, kind: cmd_q.kind,
		temp: (cmd_q.kind == KIND_EXEC) ? cmd_q.temp : 1'b0};

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		bwt_entry_t up_i;
		logic       take_i;
		logic       down_i;
		if (i == 0) begin : g_head
			assign up_i = ins_entry;
			assign take_i = insert_go;
		end else begin : g_body
			assign up_i = ent[i-1];
			assign take_i = shift_en;
		end
		if (i == TABLE_ENTRIES - 1) begin : g_tail
			assign down_i = 1'b1;
		end else begin : g_next
			assign down_i = ent[i+1].valid;
		end
		bwt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up         (up_i),
			.take_en    (take_i),
			.give_en    (shift_en),
			.down_valid (down_i),
			.exec_en    (exec_en),
			.cmd        (cmd_q),
			.ent        (ent[i]),
			.m          (mt[i])
		);
	end

	always_comb begin
		exists = 1'b0;
		any_temp = 1'b0;
		any_chk = 1'b0;
		all_valid = 1'b1;
		rd_pres = 1'b0;
		wr_pres = 1'b0;
		ex_pres = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			exists = exists | mt[i].exact;
			any_temp = any_temp | mt[i].exact_temp;
			any_chk = any_chk | mt[i].chk;
			all_valid = all_valid & ent[i].valid;
			rd_pres = rd_pres | (ent[i].valid && ent[i].kind == KIND_READ);
			wr_pres = wr_pres | (ent[i].valid && ent[i].kind == KIND_WRITE);
			ex_pres = ex_pres | (ent[i].valid && ent[i].kind == KIND_EXEC);
		end
	end

	assign add_op = (cmd_q.op == OP_ADD) || (cmd_q.op == OP_TOGGLE);
	assign need_insert = add_op && (cmd_q.kind != KIND_NONE) && !exists;

	always_comb begin
		state_d = state_q;
		shift_en = 1'b0;
		exec_en = 1'b0;
		insert_go = 1'b0;
		res_set = 1'b0;
		load_out = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				shift_en = 1'b1;
				req.ready = 1'b1;
				if (req.valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (need_insert && ent[0].valid && !all_valid) begin
					shift_en = 1'b1;
				end else begin
					exec_en = 1'b1;
					insert_go = need_insert && !ent[0].valid;
					res_set = 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				shift_en = 1'b1;
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					req.ready = 1'b1;
					state_d = req.valid ? ST_EXEC : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_comb begin
		hit_d = HIT_NONE;
		changed_d = 1'b0;
		full_d = 1'b0;
		case (cmd_q.op)
			OP_ADD, OP_REMOVE, OP_TOGGLE, OP_EXEC_CHK: begin
				if (exists)
					hit_d = any_temp ? HIT_TEMP : HIT_SET;
			end
			OP_ACCESS, OP_RANGE: hit_d = any_chk ? HIT_SET : HIT_NONE;
			default: hit_d = HIT_NONE;
		endcase
		if (need_insert) begin
			changed_d = !ent[0].valid;
			full_d = ent[0].valid;
		end
		if (cmd_q.op == OP_ADD && cmd_q.kind == KIND_EXEC && !cmd_q.temp && any_temp)
			changed_d = 1'b1;
		if ((cmd_q.op == OP_REMOVE || cmd_q.op == OP_TOGGLE) && exists)
			changed_d = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op <= bwt_op_t'(req.data.operation);
			cmd_q.kind <= (req.data.operation == OP_EXEC_CHK) ? KIND_EXEC : req.data.bp_kind;
			cmd_q.addr <= req.data.target_address;
			cmd_q.end_addr <= req.data.target_address + req.data.range_bytes;
			cmd_q.size <= req.data.access_size_log2;
			cmd_q.temp <= req.data.is_temporary;
			cmd_q.drop <= req.data.drop_temporary;
		end
		if (res_set) begin
			hit_q <= hit_d;
			changed_q <= changed_d;
			full_q <= full_d;
		end
		if (load_out) begin
			out_data_q.hit_state <= hit_q;
			out_data_q.changed <= changed_q;
			out_data_q.table_full <= full_q;
			out_data_q.read_present <= rd_pres;
			out_data_q.write_present <= wr_pres;
			out_data_q.exec_present <= ex_pres;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_data_q;

endmodule

// ----- tb/sv/tb_breakpoint_watchpoint_table.sv -----
// Testbench for the breakpoint table: directed and random commands checked against a set-based model.
`timescale 1ns / 100ps

module tb_breakpoint_watchpoint_table;
	import bwt_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int POOL_SIZE     = 12;
	localparam int RANDOM_BEATS  = 1150;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 100;

	class bp_scoreboard;
		bit       entry_temp [bit [33:0]];
		bwt_rsp_t status_due [$];
		int       errors;
		int       commands;
		int       full_refusals;
		int       check_hits;
		int       oneshot_drops;

		function bit store_entry(bit [33:0] key, bit temp);
			if (entry_temp.size() >= TABLE_ENTRIES)
				return 1'b0;
			entry_temp[key] = (key[33:32] == KIND_EXEC) ? temp : 1'b0;
			return 1'b1;
		endfunction

		function void note_request(bwt_req_t beat);
			bwt_rsp_t   st;
			bwt_op_t    op;
			bit [33:0]  key;
			bit [33:0]  doomed [$];
			bit [31:0]  mask;
			bit [31:0]  range_end;
			bit         present;
			st = '0;
			op = bwt_op_t'(beat.operation);
			key = {beat.bp_kind, beat.target_address};
			present = entry_temp.exists(key);
			commands++;
			case (op)
				OP_ADD, OP_REMOVE, OP_TOGGLE: begin
					if (beat.bp_kind != KIND_NONE) begin
						if (present)
							st.hit_state = entry_temp[key] ? HIT_TEMP : HIT_SET;
						if (op == OP_ADD) begin
							if (!present) begin
								if (store_entry(key, beat.is_temporary))
									st.changed = 1'b1;
								else
									st.table_full = 1'b1;
							end else if (beat.bp_kind == KIND_EXEC && !beat.is_temporary &&
									entry_temp[key]) begin
								entry_temp[key] = 1'b0;
								st.changed = 1'b1;
							end
						end else if (present) begin
							entry_temp.delete(key);
							st.changed = 1'b1;
						end else if (op == OP_TOGGLE) begin
							if (store_entry(key, beat.is_temporary))
								st.changed = 1'b1;
							else
								st.table_full = 1'b1;
						end
					end
				end
				OP_CLR_KIND: begin
					foreach (entry_temp[k])
						if (k[33:32] == beat.bp_kind)
							doomed.push_back(k);
					foreach (doomed[i])
						entry_temp.delete(doomed[i]);
				end
				OP_CLR_ALL: entry_temp.delete();
				OP_ACCESS: begin
					mask = ~((32'd1 << beat.access_size_log2) - 32'd1);
					foreach (entry_temp[k])
						if (k[33:32] == beat.bp_kind && (k[31:0] & mask) == beat.target_address)
							st.hit_state = HIT_SET;
				end
				OP_RANGE: begin
					range_end = beat.target_address + beat.range_bytes;
					foreach (entry_temp[k])
						if (k[33:32] == KIND_WRITE && k[31:0] >= beat.target_address &&
								k[31:0] < range_end)
							st.hit_state = HIT_SET;
				end
				default: begin
					key = {KIND_EXEC, beat.target_address};
					if (entry_temp.exists(key)) begin
						if (entry_temp[key]) begin
							st.hit_state = HIT_TEMP;
							if (beat.drop_temporary) begin
								entry_temp.delete(key);
								oneshot_drops++;
							end
						end else begin
							st.hit_state = HIT_SET;
						end
					end
				end
			endcase
			foreach (entry_temp[k])
				case (k[33:32])
					KIND_READ:  st.read_present = 1'b1;
					KIND_WRITE: st.write_present = 1'b1;
					default:    st.exec_present = 1'b1;
				endcase
			if (st.table_full)
				full_refusals++;
			if (op inside {OP_ACCESS, OP_RANGE, OP_EXEC_CHK} && st.hit_state != HIT_NONE)
				check_hits++;
			status_due.push_back(st);
		endfunction

		function void field_check(string name, int want, int got);
			if (want != got) begin
				errors++;
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		function void check_result(bwt_rsp_t got);
			bwt_rsp_t want;
			if (status_due.size() == 0) begin
				errors++;
				$error("status beat with no command pending");
				return;
			end
			want = status_due.pop_front();
			field_check("hit_state", want.hit_state, got.hit_state);
			field_check("changed", want.changed, got.changed);
			field_check("table_full", want.table_full, got.table_full);
			field_check("read_present", want.read_present, got.read_present);
			field_check("write_present", want.write_present, got.write_present);
			field_check("exec_present", want.exec_present, got.exec_present);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bwt_req_if req_ch();
	bwt_rsp_if rsp_ch();

	breakpoint_watchpoint_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bp_scoreboard board = new();
	bit           idle_on;
	int           beats_sent;
	int           stall_cycles;
	logic [31:0]  addr_pool [POOL_SIZE];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no beat moved for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int next_gap();
		return idle_on ? $urandom_range(0, 7) : 0;
	endfunction

	function automatic bwt_req_t mk(bwt_op_t op, logic [1:0] kind, logic [31:0] addr,
			logic [1:0] size, logic [31:0] len, logic temp, logic drop);
		bwt_req_t c;
		c.operation        = op;
		c.bp_kind          = kind;
		c.target_address   = addr;
		c.access_size_log2 = size;
		c.range_bytes      = len;
		c.is_temporary     = temp;
		c.drop_temporary   = drop;
		return c;
	endfunction

	// well-formed command aimed at the current address pool
	function automatic bwt_req_t make_pool_cmd();
		bwt_req_t    c;
		logic [95:0] raw;
		int          pick;
		logic [31:0] a;
		raw = {$urandom, $urandom, $urandom};
		c = raw[$bits(bwt_req_t)-1:0];
		pick = $urandom_range(0, 99);
		a = addr_pool[$urandom_range(0, POOL_SIZE - 1)] + 32'($urandom_range(0, 7));
		c.bp_kind = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
		c.target_address = a;
		if (pick < 26) begin
			c.operation = OP_ADD;
		end else if (pick < 36) begin
			c.operation = OP_REMOVE;
		end else if (pick < 46) begin
			c.operation = OP_TOGGLE;
		end else if (pick < 66) begin
			c.operation = OP_ACCESS;
			if ($urandom_range(0, 4) != 0)
				c.target_address = a & ~((32'd1 << c.access_size_log2) - 32'd1);
		end else if (pick < 76) begin
			c.operation = OP_RANGE;
			c.target_address = a - 32'($urandom_range(0, 8));
			c.range_bytes = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 16));
		end else if (pick < 79) begin
			c.operation = OP_CLR_KIND;
		end else if (pick < 80) begin
			c.operation = OP_CLR_ALL;
		end else begin
			c.operation = OP_EXEC_CHK;
		end
		return c;
	endfunction

	task automatic send_beat(bwt_req_t beat);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= beat;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		board.note_request(beat);
		beats_sent++;
	endtask

	task automatic take_status();
		int stall;
		forever begin
			stall = next_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
			board.check_result(rsp_ch.data);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (board.status_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		idle_on = 1'b1;
		send_beat(mk(OP_ACCESS, KIND_READ, 32'h0, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_ADD, KIND_READ, 32'h0000_0000, 2'd0, 32'h0, 1'b1, 1'b0));
		send_beat(mk(OP_ADD, KIND_WRITE, 32'hFFFF_FFFF, 2'd0, 32'h0, 1'b1, 1'b0));
		send_beat(mk(OP_ADD, KIND_EXEC, 32'h0000_1000, 2'd0, 32'h0, 1'b1, 1'b0));
		send_beat(mk(OP_ADD, KIND_EXEC, 32'h0000_1000, 2'd0, 32'h0, 1'b1, 1'b0));
		// permanent re-add strips the one-shot mark
		send_beat(mk(OP_ADD, KIND_EXEC, 32'h0000_1000, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_EXEC_CHK, KIND_READ, 32'h0000_1000, 2'd0, 32'h0, 1'b0, 1'b1));
		send_beat(mk(OP_TOGGLE, KIND_EXEC, 32'h0000_2000, 2'd0, 32'h0, 1'b1, 1'b0));
		send_beat(mk(OP_EXEC_CHK, KIND_EXEC, 32'h0000_2000, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_EXEC_CHK, KIND_EXEC, 32'h0000_2000, 2'd0, 32'h0, 1'b0, 1'b1));
		send_beat(mk(OP_EXEC_CHK, KIND_EXEC, 32'h0000_2000, 2'd0, 32'h0, 1'b0, 1'b1));
		send_beat(mk(OP_ADD, KIND_READ, 32'h0000_0013, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_ACCESS, KIND_READ, 32'h0000_0013, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_ACCESS, KIND_READ, 32'h0000_0012, 2'd1, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_ACCESS, KIND_READ, 32'h0000_0010, 2'd2, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_ACCESS, KIND_READ, 32'h0000_0010, 2'd3, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_ACCESS, KIND_READ, 32'h0000_0013, 2'd3, 32'h0, 1'b0, 1'b0));
		// wrapped range end matches nothing
		send_beat(mk(OP_RANGE, KIND_READ, 32'hFFFF_FFF0, 2'd0, 32'h20, 1'b0, 1'b0));
		send_beat(mk(OP_RANGE, KIND_WRITE, 32'hFFFF_FFF0, 2'd0, 32'h0F, 1'b0, 1'b0));
		send_beat(mk(OP_ADD, KIND_WRITE, 32'h8000_0000, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_RANGE, KIND_EXEC, 32'h7FFF_FFFF, 2'd0, 32'h2, 1'b0, 1'b0));
		send_beat(mk(OP_RANGE, KIND_WRITE, 32'h8000_0000, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_ADD, KIND_NONE, 32'h0000_0013, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_ACCESS, KIND_NONE, 32'h0000_0013, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_TOGGLE, KIND_READ, 32'h0000_0000, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_REMOVE, KIND_WRITE, 32'hFFFF_FFFF, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_REMOVE, KIND_WRITE, 32'hFFFF_FFFF, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_CLR_KIND, KIND_WRITE, 32'h0, 2'd0, 32'h0, 1'b0, 1'b0));
		send_beat(mk(OP_CLR_ALL, KIND_READ, 32'h0, 2'd0, 32'h0, 1'b0, 1'b0));
	endtask

	task automatic run_random();
		int          phase_no;
		int          pick;
		bwt_req_t    c;
		logic [95:0] raw;
		phase_no = 0;
		while (beats_sent < RANDOM_BEATS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// fill the table past capacity, then empty it again
				repeat (TABLE_ENTRIES + 6)
					send_beat(mk(OP_ADD, 2'($urandom_range(0, 2)), $urandom, 2'($urandom),
						$urandom, 1'($urandom), 1'($urandom)));
				repeat (4)
					send_beat(mk(OP_TOGGLE, 2'($urandom_range(0, 2)), $urandom, 2'($urandom),
						$urandom, 1'($urandom), 1'($urandom)));
				repeat (4)
					send_beat(make_pool_cmd());
				if ($urandom_range(0, 1) == 0) begin
					send_beat(mk(OP_CLR_ALL, 2'($urandom), $urandom, 2'($urandom), $urandom,
						1'($urandom), 1'($urandom)));
				end else begin
					for (int k = 0; k < 4; k++)
						send_beat(mk(OP_CLR_KIND, 2'(k), $urandom, 2'($urandom), $urandom,
							1'($urandom), 1'($urandom)));
				end
			end else if (pick < 80) begin
				foreach (addr_pool[i])
					addr_pool[i] = $urandom & ~32'h7;
				if ($urandom_range(0, 2) == 0) begin
					addr_pool[0] = 32'h0000_0000;
					addr_pool[1] = 32'hFFFF_FFF8;
				end
				repeat ($urandom_range(30, 50))
					send_beat(make_pool_cmd());
			end else begin
				repeat ($urandom_range(10, 20)) begin
					raw = {$urandom, $urandom, $urandom};
					c = raw[$bits(bwt_req_t)-1:0];
					send_beat(c);
				end
			end
			if (phase_no == 0 || $urandom_range(0, 2) == 0)
				drain();
			phase_no++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		idle_on = 1'b1;
		beats_sent = 0;
		stall_cycles = 0;
		foreach (addr_pool[i])
			addr_pool[i] = $urandom & ~32'h7;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			take_status();
		join_none
		run_directed();
		run_random();
		req_ch.valid <= 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.status_due.size() != 0) begin
			board.errors++;
			$error("%0d status beats never arrived", board.status_due.size());
		end
		$display("%0d commands over all eight operations, %0d adds refused on a full table",
			board.commands, board.full_refusals);
		$display("%0d check hits, %0d one-shot entries consumed, %0d mismatches",
			board.check_hits, board.oneshot_drops, board.errors);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bwt_pkg.sv
hw/rtl/bwt_ifs.sv
hw/rtl/bwt_cell.sv
hw/rtl/breakpoint_watchpoint_table.sv
tb/sv/tb_breakpoint_watchpoint_table.sv
